// ===== hw/rtl/sfp_pkg.sv =====
// Shared types and constants of the sonar frame parser.
`timescale 1ns / 1ps

package sfp_pkg;

    // Frame sync bytes 'B' and 'R'.
    localparam logic [7:0] SYNC_FIRST  = 8'h42;
    localparam logic [7:0] SYNC_SECOND = 8'h52;

    localparam int BYTE_W      = 8;
    localparam int ID_W        = 16;
    localparam int SUM_W       = 16;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int OUT_DATA_W  = 136;
    localparam int OUT_USER_W  = 5;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_ID_DISTANCE    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ID_FIRMWARE    = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ID_SOUND_SPEED = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ID_DEVICE      = 8'd3;

    // Default message ids after reset.
    localparam logic [ID_W-1:0] RST_ID_DISTANCE    = 16'd1211;
    localparam logic [ID_W-1:0] RST_ID_FIRMWARE    = 16'd5;
    localparam logic [ID_W-1:0] RST_ID_SOUND_SPEED = 16'd1203;
    localparam logic [ID_W-1:0] RST_ID_DEVICE      = 16'd1201;

    typedef logic [1:0] t_status;
    localparam t_status STATUS_OK       = 2'd0;
    localparam t_status STATUS_CHECKSUM = 2'd1;
    localparam t_status STATUS_BAD_ID   = 2'd2;
    localparam t_status STATUS_NO_SYNC  = 2'd3;

    typedef logic [2:0] t_kind;
    localparam t_kind KIND_DISTANCE    = 3'd0;
    localparam t_kind KIND_FIRMWARE    = 3'd1;
    localparam t_kind KIND_SOUND_SPEED = 3'd2;
    localparam t_kind KIND_DEVICE      = 3'd3;
    localparam t_kind KIND_OTHER       = 3'd4;

    // Per-byte event from the deframer to the decoder.
    typedef struct packed {
        logic            done;      // checksum high byte taken, frame finished
        logic            sync_err;  // second sync byte was wrong
        logic            sum_ok;    // received checksum matches running sum
        logic [ID_W-1:0] frame_id;
    } t_frame_evt;

    typedef struct packed {
        t_status         status;
        t_kind           kind;
        logic [ID_W-1:0] frame_id;
        logic [31:0]     distance;
        logic [7:0]      confidence;
        logic [31:0]     sound_speed;
        logic [7:0]      version_major;
        logic [7:0]      version_minor;
        logic [7:0]      version_patch;
        logic [7:0]      device_number;
        logic [15:0]     sync_error_count;
    } t_result;

endpackage

// ===== hw/rtl/sonar_frame_parser.sv =====
// Top level of the sonar frame parser: deframer, decoder and output skid buffer.
`timescale 1ns / 1ps
// A result is registered into the output register, or the skid register while that is held, as
// the byte that ends a frame (checksum high byte) or breaks sync (wrong second sync byte) is taken.
// Throughput: one byte per cycle while ready is high; each needs one phase step and one 16-bit add.
// Input ready drops only while both the output register and the skid register hold results.
// Reset (synchronous, active low) empties the output stages, returns the parser to waiting for
// 'B', zeroes all decoded values and the error count, and loads the default message ids.

module sonar_frame_parser
    import sfp_pkg::*;
#(
    parameter int CAPTURE_BYTES = 5
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Received byte stream.
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [7:0]             i_s_tdata,   // [7:0] rx_byte
    // Frame results.
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // [15:0] frame_id, [47:16] distance, [55:48] confidence, [87:56] sound_speed,
    // [95:88] version_major, [103:96] version_minor, [111:104] version_patch,
    // [119:112] device_number, [135:120] sync_error_count
    output logic [OUT_DATA_W-1:0]  o_m_tdata,
    output logic [OUT_USER_W-1:0]  o_m_tuser,   // [1:0] frame_status, [4:2] frame_kind
    // Message id register writes.
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic                                 s_accept;
    t_frame_evt                           evt;
    logic [CAPTURE_BYTES-1:0][BYTE_W-1:0] capture;
    logic                                 result_valid;
    t_result                              result;
    logic                                 push;
    logic                                 pop;

    // Output register plus one skid entry.
    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;

    // Configuration writes are always taken; they land in the id registers directly.
    assign o_cfg_ready = 1'b1;

    // Each accepted byte gives at most one result, so a free skid entry is enough
    // to take the next byte no matter what the master side does.
    assign o_s_tready = !r_skid_valid;
    assign s_accept   = i_s_tvalid && o_s_tready;

    sfp_deframer #(
        .CAPTURE_BYTES(CAPTURE_BYTES)
    ) u_deframer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_accept),
        .i_byte    (i_s_tdata),
        .o_evt     (evt),
        .o_capture (capture)
    );

    sfp_decode #(
        .CAPTURE_BYTES(CAPTURE_BYTES)
    ) u_decode (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_evt          (evt),
        .i_capture      (capture),
        .o_result_valid (result_valid),
        .o_result       (result)
    );

    // The deframer only flags events for accepted bytes, so a result here is a push.
    assign push = result_valid;
    assign pop  = r_out_valid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || pop) begin
            // Output register is free this cycle: refill from skid first, else from the new result.
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= push;
            end
        end else if (push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || pop) begin
            r_out <= r_skid_valid ? r_skid : result;
        end
        if (r_out_valid && !pop && push) begin
            r_skid <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out.sync_error_count, r_out.device_number, r_out.version_patch,
                         r_out.version_minor, r_out.version_major, r_out.sound_speed,
                         r_out.confidence, r_out.distance, r_out.frame_id};
    assign o_m_tuser  = {r_out.kind, r_out.status};

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while output register is empty");

    a_skid_kept_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_m_tready) |=> r_skid_valid)
        else $error("skid entry lost while the master side stalled");

    a_skid_drains_on_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(r_skid_valid) && $past(i_rst_n)) |-> $past(r_out_valid && i_m_tready))
        else $error("skid entry left without an output word being taken");

endmodule

// ===== hw/rtl/sfp_deframer.sv =====
// Byte-level frame state machine with running checksum and payload capture.
`timescale 1ns / 1ps

module sfp_deframer
    import sfp_pkg::*;
#(
    parameter int CAPTURE_BYTES = 5
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic [BYTE_W-1:0]                   i_byte,
    output t_frame_evt                          o_evt,
    output logic [CAPTURE_BYTES-1:0][BYTE_W-1:0] o_capture
);

    localparam logic [3:0] PH_WAIT    = 4'd0;
    localparam logic [3:0] PH_SYNC    = 4'd1;
    localparam logic [3:0] PH_LEN_LO  = 4'd2;
    localparam logic [3:0] PH_LEN_HI  = 4'd3;
    localparam logic [3:0] PH_ID_LO   = 4'd4;
    localparam logic [3:0] PH_ID_HI   = 4'd5;
    localparam logic [3:0] PH_SRC     = 4'd6;
    localparam logic [3:0] PH_DEV     = 4'd7;
    localparam logic [3:0] PH_PAYLOAD = 4'd8;
    localparam logic [3:0] PH_CK_LO   = 4'd9;
    localparam logic [3:0] PH_CK_HI   = 4'd10;

    logic [3:0]                           r_phase, n_phase;
    logic [BYTE_W-1:0]                    r_len, n_len;
    logic [BYTE_W-1:0]                    r_idx, n_idx;
    logic [SUM_W-1:0]                     r_sum, n_sum;
    logic [ID_W-1:0]                      r_id, n_id;
    logic [BYTE_W-1:0]                    r_ck_lo, n_ck_lo;
    logic [CAPTURE_BYTES-1:0][BYTE_W-1:0] r_capture, n_capture;
    logic [SUM_W-1:0]                     sum_add;
    logic [BYTE_W-1:0]                    idx_inc;

    assign sum_add = r_sum + {{(SUM_W-BYTE_W){1'b0}}, i_byte};
    assign idx_inc = r_idx + 8'd1;

    always_comb begin
        n_phase   = r_phase;
        n_len     = r_len;
        n_idx     = r_idx;
        n_sum     = r_sum;
        n_id      = r_id;
        n_ck_lo   = r_ck_lo;
        n_capture = r_capture;
        o_evt     = '0;
        o_evt.frame_id = r_id;
        o_evt.sum_ok   = ({i_byte, r_ck_lo} == r_sum);
        if (i_valid) begin
            unique case (r_phase)
                PH_WAIT: begin
                    if (i_byte == SYNC_FIRST) begin
                        n_capture = '0;
                        n_sum     = {{(SUM_W-BYTE_W){1'b0}}, i_byte};
                        n_id      = '0;
                        n_len     = '0;
                        n_idx     = '0;
                        n_phase   = PH_SYNC;
                    end
                end
                PH_SYNC: begin
                    if (i_byte != SYNC_SECOND) begin
                        o_evt.sync_err = 1'b1;
                        n_phase        = PH_WAIT;
                    end else begin
                        n_sum   = sum_add;
                        n_phase = PH_LEN_LO;
                    end
                end
                PH_LEN_LO: begin
                    n_len   = i_byte;
                    n_id    = '0;
                    n_sum   = sum_add;
                    n_phase = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    n_sum   = sum_add;
                    n_phase = PH_ID_LO;
                end
                PH_ID_LO: begin
                    n_id    = {{(ID_W-BYTE_W){1'b0}}, i_byte};
                    n_sum   = sum_add;
                    n_phase = PH_ID_HI;
                end
                PH_ID_HI: begin
                    n_id    = {i_byte, r_id[BYTE_W-1:0]};
                    n_sum   = sum_add;
                    n_phase = PH_SRC;
                end
                PH_SRC: begin
                    n_sum   = sum_add;
                    n_phase = PH_DEV;
                end
                PH_DEV: begin
                    n_sum   = sum_add;
                    n_idx   = '0;
                    n_phase = (r_len == '0) ? PH_CK_LO : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    for (int i = 0; i < CAPTURE_BYTES; i++) begin
                        if (r_idx == 8'(i)) begin
                            n_capture[i] = i_byte;
                        end
                    end
                    n_sum = sum_add;
                    n_idx = idx_inc;
                    if (idx_inc >= r_len) begin
                        n_phase = PH_CK_LO;
                    end
                end
                PH_CK_LO: begin
                    n_ck_lo = i_byte;
                    n_phase = PH_CK_HI;
                end
                PH_CK_HI: begin
                    o_evt.done = 1'b1;
                    n_phase    = PH_WAIT;
                end
                default: begin
                    n_phase = PH_WAIT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_WAIT;
            r_len     <= '0;
            r_idx     <= '0;
            r_sum     <= '0;
            r_id      <= '0;
            r_ck_lo   <= '0;
            r_capture <= '0;
        end else begin
            r_phase   <= n_phase;
            r_len     <= n_len;
            r_idx     <= n_idx;
            r_sum     <= n_sum;
            r_id      <= n_id;
            r_ck_lo   <= n_ck_lo;
            r_capture <= n_capture;
        end
    end

    assign o_capture = r_capture;

    a_payload_has_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_len != '0))
        else $error("payload phase entered with zero length");

    a_index_below_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_idx < r_len))
        else $error("payload index ran past the length");

    a_sum_starts_at_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && (r_phase == PH_WAIT) && (i_byte == SYNC_FIRST))
        |=> (r_sum == {{(SUM_W-BYTE_W){1'b0}}, SYNC_FIRST}))
        else $error("checksum did not restart at frame start");

endmodule

// ===== hw/rtl/sfp_decode.sv =====
// Message id registers, frame classification and last decoded values.
`timescale 1ns / 1ps

module sfp_decode
    import sfp_pkg::*;
#(
    parameter int CAPTURE_BYTES = 5
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]               i_cfg_index,
    input  logic [CFG_DATA_W-1:0]                i_cfg_data,
    input  t_frame_evt                           i_evt,
    input  logic [CAPTURE_BYTES-1:0][BYTE_W-1:0] i_capture,
    output logic                                 o_result_valid,
    output t_result                              o_result
);

    logic [ID_W-1:0] r_id_distance, r_id_firmware, r_id_sound_speed, r_id_device;
    logic [31:0]     r_distance, n_distance;
    logic [7:0]      r_confidence, n_confidence;
    logic [31:0]     r_sound_speed, n_sound_speed;
    logic [2:0][7:0] r_version, n_version;
    logic [7:0]      r_device, n_device;
    logic [15:0]     r_tally, n_tally;
    t_kind           kind;
    t_status         status;
    logic [31:0]     capture_word;

    assign capture_word = {i_capture[3], i_capture[2], i_capture[1], i_capture[0]};

    always_comb begin
        priority if (i_evt.frame_id == r_id_distance)    kind = KIND_DISTANCE;
        else if (i_evt.frame_id == r_id_firmware)        kind = KIND_FIRMWARE;
        else if (i_evt.frame_id == r_id_sound_speed)     kind = KIND_SOUND_SPEED;
        else if (i_evt.frame_id == r_id_device)          kind = KIND_DEVICE;
        else                                             kind = KIND_OTHER;

        // A bad checksum outranks an unknown id.
        priority if (!i_evt.sum_ok)     status = STATUS_CHECKSUM;
        else if (kind == KIND_OTHER)    status = STATUS_BAD_ID;
        else                            status = STATUS_OK;
    end

    always_comb begin
        n_distance    = r_distance;
        n_confidence  = r_confidence;
        n_sound_speed = r_sound_speed;
        n_version     = r_version;
        n_device      = r_device;
        n_tally       = r_tally;
        if (i_evt.sync_err && (r_tally != 16'hFFFF)) begin
            n_tally = r_tally + 16'd1;
        end
        if (i_evt.done && (status == STATUS_OK)) begin
            unique case (kind)
                KIND_DISTANCE: begin
                    n_distance   = capture_word;
                    n_confidence = i_capture[4];
                end
                KIND_FIRMWARE: begin
                    n_version = {i_capture[2], i_capture[1], i_capture[0]};
                end
                KIND_SOUND_SPEED: begin
                    n_sound_speed = capture_word;
                end
                KIND_DEVICE: begin
                    n_device = i_capture[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_distance    <= RST_ID_DISTANCE;
            r_id_firmware    <= RST_ID_FIRMWARE;
            r_id_sound_speed <= RST_ID_SOUND_SPEED;
            r_id_device      <= RST_ID_DEVICE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ID_DISTANCE:    r_id_distance    <= i_cfg_data;
                CFG_ID_FIRMWARE:    r_id_firmware    <= i_cfg_data;
                CFG_ID_SOUND_SPEED: r_id_sound_speed <= i_cfg_data;
                CFG_ID_DEVICE:      r_id_device      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_distance    <= '0;
            r_confidence  <= '0;
            r_sound_speed <= '0;
            r_version     <= '0;
            r_device      <= '0;
            r_tally       <= '0;
        end else begin
            r_distance    <= n_distance;
            r_confidence  <= n_confidence;
            r_sound_speed <= n_sound_speed;
            r_version     <= n_version;
            r_device      <= n_device;
            r_tally       <= n_tally;
        end
    end

    // Results carry the values as they stand after this frame.
    always_comb begin
        o_result_valid            = i_evt.done | i_evt.sync_err;
        o_result.status           = i_evt.sync_err ? STATUS_NO_SYNC : status;
        o_result.kind             = i_evt.sync_err ? KIND_OTHER : kind;
        o_result.frame_id         = i_evt.sync_err ? '0 : i_evt.frame_id;
        o_result.distance         = n_distance;
        o_result.confidence       = n_confidence;
        o_result.sound_speed      = n_sound_speed;
        o_result.version_major    = n_version[0];
        o_result.version_minor    = n_version[1];
        o_result.version_patch    = n_version[2];
        o_result.device_number    = n_device;
        o_result.sync_error_count = n_tally;
    end

    a_tally_never_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_tally >= $past(r_tally)))
        else $error("sync error count went down");

    a_ok_means_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_result.status == STATUS_OK)) |-> (o_result.kind != KIND_OTHER))
        else $error("frame reported good with an unknown id");

    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_evt.done && i_evt.sync_err))
        else $error("frame end and sync error on the same byte");

endmodule
